FILE: rtl/core/dual_sum_frame_deframer_top_assert.svh
// Assertion macros used by the deframer scan sequencer (dsfd_scan).
// DSFD_ASSERT_IMP checks an implication in the same cycle.
// DSFD_ASSERT_NXT checks an implication in the next cycle.
`ifndef DUAL_SUM_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define DUAL_SUM_FRAME_DEFRAMER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define DSFD_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);
`define DSFD_ASSERT_NXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define DSFD_ASSERT_IMP(lbl, clk, rstn, pre, post, msg)
`define DSFD_ASSERT_NXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

FILE: rtl/core/dsfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dsfd_pkg;

  // Reset value of the sync marker register.
  localparam logic [7:0] SYNC_RESET = 8'hAA;

  // Frame layout: sync, address, id, length, data, two check bytes.
  localparam int unsigned ADDR_OFFSET    = 1;
  localparam int unsigned ID_OFFSET      = 2;
  localparam int unsigned LEN_OFFSET     = 3;
  localparam int unsigned HDR_BYTES      = 4;
  localparam int unsigned CK_BYTES       = 2;
  localparam int unsigned FRAME_OVERHEAD = HDR_BYTES + CK_BYTES;

  // Packed width of the result tdata bus (35 bits of fields, byte padded).
  localparam int unsigned OUT_TDATA_W = 40;

  // Scan sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SYNC_RD,
    S_SYNC_EV,
    S_LEN_EV,
    S_SUM_EV,
    S_EMIT_RD,
    S_EMIT_EV,
    S_DONE
  } dsfd_state_t;

  // One result item as produced by the sequencer.
  typedef struct packed {
    logic [7:0] frame_addr;
    logic [7:0] frame_id;
    logic [5:0] data_len;
    logic [4:0] byte_index;
    logic [7:0] data_byte;
    logic       frame_last;
  } dsfd_res_t;

  // Requests from the sequencer to the output stage.
  typedef struct packed {
    logic push;
    logic flush;
  } dsfd_ctl_t;

  // Status from the output stage back to the sequencer.
  typedef struct packed {
    logic push_ok;
    logic flush_ok;
  } dsfd_ost_t;

endpackage

`default_nettype wire

FILE: rtl/core/dsfd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dsfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 38
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dsfd_out.sv
`timescale 1ns / 1ps
`default_nettype none

module dsfd_out (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dsfd_pkg::dsfd_ctl_t ctl,
  input  wire dsfd_pkg::dsfd_res_t res,
  output dsfd_pkg::dsfd_ost_t      ost,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output dsfd_pkg::dsfd_res_t      out_res,
  output logic                     out_run_last
);

  import dsfd_pkg::*;

  logic      hold_v_r, hold_v_nxt;
  dsfd_res_t hold_r;
  logic      out_v_r, out_v_nxt;
  dsfd_res_t out_r;
  logic      run_last_r;
  logic      out_free;
  logic      move;

  // The newest result waits in the hold stage until the sequencer knows
  // whether another result of the same transaction follows it.
  always_comb begin
    out_free     = !out_v_r || out_tready;
    move         = hold_v_r && out_free && (ctl.push || ctl.flush);
    ost.push_ok  = !hold_v_r || out_free;
    ost.flush_ok = !hold_v_r || out_free;
  end

  // Valid flags of both stages.
  always_comb begin
    hold_v_nxt = hold_v_r;
    out_v_nxt  = out_v_r;
    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end
    if (move) begin
      out_v_nxt  = 1'b1;
      hold_v_nxt = 1'b0;
    end
    if (ctl.push && ost.push_ok) begin
      hold_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (move) begin
      out_r      <= hold_r;
      run_last_r <= ctl.flush;
    end
    if (ctl.push && ost.push_ok) begin
      hold_r <= res;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_res      = out_r;
  assign out_run_last = run_last_r;

endmodule

`default_nettype wire

FILE: rtl/core/dsfd_scan.sv
`timescale 1ns / 1ps
`default_nettype none
`include "dual_sum_frame_deframer_top_assert.svh"

module dsfd_scan #(
  parameter int unsigned MAX_DATA_BYTES = 32,
  parameter int unsigned DEPTH          = 38
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic                     in_action,
  input  wire logic [7:0]               in_byte,
  input  wire logic                     cfg_wr_en,
  input  wire logic [7:0]               cfg_wr_data,
  output logic                          wr_en,
  output logic      [$clog2(DEPTH)-1:0] wr_addr,
  output logic      [7:0]               wr_data,
  output logic                          rd_en,
  output logic      [$clog2(DEPTH)-1:0] rd_addr,
  input  wire logic [7:0]               rd_data,
  input  wire dsfd_pkg::dsfd_ost_t      ost,
  output dsfd_pkg::dsfd_ctl_t           ctl,
  output dsfd_pkg::dsfd_res_t           res
);

  import dsfd_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > 9) ? CW : 9;
  localparam logic [PW+1:0] DEPTH_W = (PW + 2)'(DEPTH);
  localparam logic [XW-1:0] MAX_W   = XW'(MAX_DATA_BYTES);

  dsfd_state_t   state_r, state_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    sync_r;
  logic [7:0]    len_r, len_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic [7:0]    eidx_r, eidx_nxt;
  logic [7:0]    s1_r, s1_nxt;
  logic [7:0]    s2_r, s2_nxt;
  logic          ck1_ok_r, ck1_ok_nxt;
  logic [7:0]    addr_r, addr_nxt;
  logic [7:0]    id_r, id_nxt;
  logic [PW:0]   rd_off;
  logic [PW-1:0] idx_inc;
  logic          in_accept;

  logic          sync_hit, len_over, too_short, hdr_short;
  logic          in_body, at_ck1, sums_ok, len_zero, emit_last;
  logic [XW-1:0] len_ext, fsize_rd, fsize_r, cnt_ext, body_len, idx_ext;

  // Position in the ring buffer, base plus offset, wrapped at the depth.
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                             input logic [PW:0]   off);
    logic [PW+1:0] s;
    s = {2'b00, base} + {1'b0, off};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[PW-1:0];
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign idx_inc   = idx_r + 1'b1;

  // Comparisons on the byte just read and on the current candidate.
  always_comb begin
    sync_hit  = (rd_data == sync_r);
    len_ext   = XW'(rd_data);
    len_over  = len_ext > MAX_W;
    fsize_rd  = len_ext + XW'(FRAME_OVERHEAD);
    cnt_ext   = XW'(count_r);
    too_short = cnt_ext < fsize_rd;
    hdr_short = cnt_ext < XW'(HDR_BYTES);
    body_len  = XW'(len_r) + XW'(HDR_BYTES);
    fsize_r   = XW'(len_r) + XW'(FRAME_OVERHEAD);
    idx_ext   = XW'(idx_r);
    in_body   = idx_ext < body_len;
    at_ck1    = idx_ext == body_len;
    sums_ok   = ck1_ok_r && (rd_data == s2_r);
    len_zero  = (len_r == 8'd0);
    emit_last = ((eidx_r + 8'd1) == len_r);
  end

  // Next state of the scan sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && !in_action) begin
          state_nxt = S_SYNC_RD;
        end
      end
      S_SYNC_RD: begin
        state_nxt = (count_r == '0) ? S_DONE : S_SYNC_EV;
      end
      S_SYNC_EV: begin
        if (!sync_hit) begin
          state_nxt = S_SYNC_RD;
        end else if (hdr_short) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LEN_EV;
        end
      end
      S_LEN_EV: begin
        if (len_over) begin
          state_nxt = S_SYNC_RD;
        end else if (too_short) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SUM_EV;
        end
      end
      S_SUM_EV: begin
        if (!in_body && !at_ck1) begin
          state_nxt = sums_ok ? S_EMIT_RD : S_SYNC_RD;
        end
      end
      S_EMIT_RD: begin
        if (!len_zero) begin
          state_nxt = S_EMIT_EV;
        end else if (ost.push_ok) begin
          state_nxt = S_SYNC_RD;
        end
      end
      S_EMIT_EV: begin
        if (ost.push_ok) begin
          state_nxt = emit_last ? S_SYNC_RD : S_EMIT_RD;
        end
      end
      S_DONE: begin
        if (ost.flush_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Buffer accesses, pointer updates and result requests.
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    eidx_nxt   = eidx_r;
    s1_nxt     = s1_r;
    s2_nxt     = s2_r;
    ck1_ok_nxt = ck1_ok_r;
    addr_nxt   = addr_r;
    id_nxt     = id_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_off     = '0;
    ctl.push   = 1'b0;
    ctl.flush  = 1'b0;
    res.frame_addr = addr_r;
    res.frame_id   = id_r;
    res.data_len   = len_r[5:0];
    res.byte_index = eidx_r[4:0];
    res.data_byte  = rd_data;
    res.frame_last = emit_last;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_action) begin
            count_nxt = '0;
            head_nxt  = '0;
          end else if (count_r < CW'(DEPTH)) begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
      end
      S_SYNC_RD: begin
        if (count_r != '0) begin
          rd_en = 1'b1;
        end
      end
      S_SYNC_EV: begin
        if (!sync_hit) begin
          head_nxt  = wrap_add(head_r, (PW + 1)'(1));
          count_nxt = count_r - 1'b1;
        end else if (!hdr_short) begin
          rd_en  = 1'b1;
          rd_off = (PW + 1)'(LEN_OFFSET);
        end
      end
      S_LEN_EV: begin
        if (len_over) begin
          head_nxt  = wrap_add(head_r, (PW + 1)'(1));
          count_nxt = count_r - 1'b1;
        end else if (!too_short) begin
          len_nxt = rd_data;
          idx_nxt = '0;
          s1_nxt  = '0;
          s2_nxt  = '0;
          rd_en   = 1'b1;
        end
      end
      S_SUM_EV: begin
        if (in_body) begin
          s1_nxt = s1_r + rd_data;
          s2_nxt = s2_r + s1_r + rd_data;
          if (idx_r == PW'(ADDR_OFFSET)) begin
            addr_nxt = rd_data;
          end
          if (idx_r == PW'(ID_OFFSET)) begin
            id_nxt = rd_data;
          end
          idx_nxt = idx_inc;
          rd_en   = 1'b1;
          rd_off  = {1'b0, idx_inc};
        end else if (at_ck1) begin
          ck1_ok_nxt = (rd_data == s1_r);
          idx_nxt    = idx_inc;
          rd_en      = 1'b1;
          rd_off     = {1'b0, idx_inc};
        end else if (sums_ok) begin
          eidx_nxt = '0;
        end else begin
          head_nxt  = wrap_add(head_r, (PW + 1)'(1));
          count_nxt = count_r - 1'b1;
        end
      end
      S_EMIT_RD: begin
        if (len_zero) begin
          // A frame without data yields one result with a zero byte.
          ctl.push       = 1'b1;
          res.byte_index = '0;
          res.data_byte  = '0;
          res.frame_last = 1'b1;
          if (ost.push_ok) begin
            head_nxt  = wrap_add(head_r, (PW + 1)'(fsize_r));
            count_nxt = count_r - CW'(fsize_r);
          end
        end else begin
          rd_en  = 1'b1;
          rd_off = (PW + 1)'(HDR_BYTES) + (PW + 1)'(eidx_r);
        end
      end
      S_EMIT_EV: begin
        ctl.push = 1'b1;
        if (ost.push_ok) begin
          eidx_nxt = eidx_r + 8'd1;
          if (emit_last) begin
            head_nxt  = wrap_add(head_r, (PW + 1)'(fsize_r));
            count_nxt = count_r - CW'(fsize_r);
          end
        end
      end
      S_DONE: begin
        ctl.flush = 1'b1;
      end
      default: begin
        ctl.flush = 1'b0;
      end
    endcase
  end

  // Writes only happen while idle and reads only while scanning, so the
  // buffer never sees a read and a write of the same entry overlap.
  assign wr_addr = wrap_add(head_r, (PW + 1)'(count_r));
  assign wr_data = in_byte;
  assign rd_addr = wrap_add(head_r, rd_off);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      sync_r  <= SYNC_RESET;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        sync_r <= cfg_wr_data;
      end
    end
  end

  // Candidate frame working registers.
  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    idx_r    <= idx_nxt;
    eidx_r   <= eidx_nxt;
    s1_r     <= s1_nxt;
    s2_r     <= s2_nxt;
    ck1_ok_r <= ck1_ok_nxt;
    addr_r   <= addr_nxt;
    id_r     <= id_nxt;
  end

  `DSFD_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH), "fill count above depth")
  `DSFD_ASSERT_IMP(a_head_bound, clk, rst_n, 1'b1, {1'b0, head_r} < (PW + 1)'(DEPTH), "head out of range")
  `DSFD_ASSERT_NXT(a_clear_empty, clk, rst_n, in_accept && in_action, count_r == '0, "clear left bytes")
  `DSFD_ASSERT_IMP(a_push_emit, clk, rst_n, ctl.push, state_r == S_EMIT_RD || state_r == S_EMIT_EV, "result outside emit")

endmodule

`default_nettype wire

FILE: rtl/core/dual_sum_frame_deframer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Transaction
// in_*      input      one received byte (push) or a buffer clear
// out_*     output     one data byte of a frame that passed both checksums (zero byte if empty)
// cfg_*     input      write of the sync marker byte
//
// A push starts a scan: bytes ahead of a sync byte are
// dropped, then the length and the rest of a full candidate are read to check
// both sums; each emitted data byte is read, then pushed. This follows from
// the single read port of the byte buffer RAM, read one entry per cycle. A
// clear needs no scan. Reset empties the buffer at once, with no sweep.
// A stalled result channel holds the sequencer in its emit or done states.

module dual_sum_frame_deframer_top #(
  parameter int unsigned MAX_DATA_BYTES = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // rx_byte
  input  wire logic                              in_tuser,   // action
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // frame_addr, frame_id, data_len, byte_index, data_byte, zero pad
  output logic      [dsfd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                   out_tlast,  // frame_last
  output logic                                   out_tuser,  // run_last
  input  wire logic                              cfg_wr_en,
  input  wire logic [7:0]                        cfg_wr_data // sync_byte
);

  import dsfd_pkg::*;

  localparam int unsigned DEPTH = MAX_DATA_BYTES + FRAME_OVERHEAD;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned PAD_W = OUT_TDATA_W - $bits(dsfd_res_t) + 1;

  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic [7:0]    rd_data;
  dsfd_ctl_t     ctl;
  dsfd_ost_t     ost;
  dsfd_res_t     res;
  dsfd_res_t     out_res;

  // Ring buffer of received bytes.
  dsfd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sync search, checksum check and frame emission.
  dsfd_scan #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES),
    .DEPTH          (DEPTH)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_action   (in_tuser),
    .in_byte     (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .ost         (ost),
    .ctl         (ctl),
    .res         (res)
  );

  // Hold stage and output register.
  dsfd_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .res          (res),
    .ost          (ost),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_res      (out_res),
    .out_run_last (out_tuser)
  );

  // Pack the result fields, first field in the lowest bits.
  assign out_tdata = {{PAD_W{1'b0}}, out_res.data_byte, out_res.byte_index,
                      out_res.data_len, out_res.frame_id, out_res.frame_addr};
  assign out_tlast = out_res.frame_last;

endmodule

`default_nettype wire
